>>> rtl/psf_pkg.sv
// Package: sequencer states and register indexes of the persistent step filter.
`default_nettype none

package psf_pkg;

    // Register index width of the configuration port.
    localparam int CFG_ADDR_W = 3;

    // Register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_LIMIT     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_LIMIT     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_BAND          = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_PERSIST_COUNT = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_AVERAGE_MODE  = 3'd4;

    // Width of the band register.
    localparam int BAND_W = 16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_STEP,
        ST_ABS,
        ST_DIV,
        ST_FIX,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

>>> rtl/persistent_step_filter_core.sv
// Top level: glitch filter with hysteresis, persistence and serial run averaging.
//
//  channel | ports                                  | direction | handshake
//  --------+----------------------------------------+-----------+-----------------
//  input   | s_valid, s_ready, s_sample             | in        | valid / ready
//  result  | m_valid, m_ready, m_held_out, m_rejected| out       | valid / ready
//  config  | cfg_wen, cfg_addr, cfg_wdata           | in        | write enable only
//
//  Sequence: an accepted item passes CHECK, STEP and DONE on its way to the
//  output register in the plain path (CHECK straight to DONE when the sample
//  is outside the limits); when a run fires in averaging mode it also passes
//  ABS, DIV and FIX, where the restoring divider in DIV retires one quotient
//  bit per cycle.
//  Reset: aresetn is synchronous, active low; it restores the register
//  defaults and clears the held value, the runs and the sum.
//  Stalls: a finished beat waits in the output register, and the next input
//  beat is taken meanwhile; the block stalls only when a second result is
//  ready while the first still waits.
`default_nettype none

module persistent_step_filter_core
    import psf_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16,
    parameter int COUNT_WIDTH  = 16
) (
    input  wire                                    aclk,
    input  wire                                    aresetn,
    // input channel
    input  wire                                    s_valid,
    output logic                                   s_ready,
    input  wire  signed [SAMPLE_WIDTH-1:0]         s_sample,
    // result channel
    output logic                                   m_valid,
    input  wire                                    m_ready,
    output logic signed [SAMPLE_WIDTH-1:0]         m_held_out,
    output logic                                   m_rejected,
    // configuration port
    input  wire                                    cfg_wen,
    input  wire  [CFG_ADDR_W-1:0]                  cfg_addr,
    input  wire  [((SAMPLE_WIDTH > BAND_W) ? SAMPLE_WIDTH : BAND_W)-1:0] cfg_wdata
);

    localparam int SW     = SAMPLE_WIDTH;
    localparam int CW     = COUNT_WIDTH;
    // A run holds at most 2^CW-1 samples, so this width never overflows.
    localparam int SUM_W  = SW + CW;
    // Compare width: held value plus or minus the band without wrap.
    localparam int CMP_W  = ((SUM_W > BAND_W) ? SUM_W : BAND_W + 1) + 1;
    localparam int CNT_W  = $clog2(SUM_W);

    localparam logic [CW-1:0]  CMAX     = {CW{1'b1}};
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(SUM_W - 1);

    localparam logic signed [SW-1:0] MAX_RST =
        (SW >= 16) ? SW'(32767) : {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] MIN_RST =
        (SW >= 16) ? SW'(-32768) : {1'b1, {(SW-1){1'b0}}};

    // configuration registers
    logic signed [SW-1:0]     max_limit_reg;
    logic signed [SW-1:0]     min_limit_reg;
    logic [BAND_W-1:0]        band_reg;
    logic [CW-1:0]            persist_reg;
    logic                     mode_reg;

    // sequencer and datapath
    state_t                   state_reg, state_next;
    logic signed [SW-1:0]     smp_reg, smp_next;
    logic                     rej_reg, rej_next;
    logic signed [SUM_W-1:0]  held_reg, held_next;
    logic [CW-1:0]            rise_reg, rise_next;
    logic [CW-1:0]            fall_reg, fall_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic [SUM_W-1:0]         quo_reg, quo_next;
    logic [CW-1:0]            rem_reg, rem_next;
    logic                     neg_reg, neg_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;

    // output register
    logic                     m_valid_reg, m_valid_next;
    logic signed [SW-1:0]     m_held_reg, m_held_next;
    logic                     m_rej_reg, m_rej_next;

    // control strobes
    logic                     take_in;
    logic                     load_out;

    // combinational terms
    logic [CW-1:0]            need;
    logic                     out_of_limits;
    logic signed [CMP_W-1:0]  smp_wide;
    logic signed [CMP_W-1:0]  held_wide;
    logic signed [CMP_W-1:0]  band_wide;
    logic signed [CMP_W-1:0]  upper;
    logic signed [CMP_W-1:0]  lower;
    logic                     is_rise;
    logic                     is_fall;
    logic [CW-1:0]            run_cur;
    logic [CW-1:0]            run_new;
    logic                     fire;
    logic signed [SUM_W-1:0]  sum_base;
    logic signed [SUM_W-1:0]  sum_step;
    logic [CW:0]              div_shift;
    logic [CW:0]              div_trial;

    // Zero persistence acts as one.
    assign need = (persist_reg == '0) ? CW'(1) : persist_reg;

    assign out_of_limits = (smp_reg > max_limit_reg) || (smp_reg < min_limit_reg);

    assign smp_wide  = {{(CMP_W-SW){smp_reg[SW-1]}}, smp_reg};
    assign held_wide = {{(CMP_W-SUM_W){held_reg[SUM_W-1]}}, held_reg};
    assign band_wide = {{(CMP_W-BAND_W){1'b0}}, band_reg};
    assign upper     = held_wide + band_wide;
    assign lower     = held_wide - band_wide;
    assign is_rise   = smp_wide > upper;
    assign is_fall   = smp_wide < lower;

    // Run that this sample extends; saturate at the counter's top.
    assign run_cur  = is_rise ? rise_reg : fall_reg;
    assign run_new  = (run_cur != CMAX) ? run_cur + CW'(1) : run_cur;
    assign fire     = run_new >= need;

    // Restart the sum when the direction turns.
    assign sum_base = (is_rise ? (fall_reg != '0) : (rise_reg != '0)) ? '0 : sum_reg;
    assign sum_step = sum_base + {{(SUM_W-SW){smp_reg[SW-1]}}, smp_reg};

    // One restoring division step: shift in the next dividend bit and try.
    assign div_shift = {rem_reg, quo_reg[SUM_W-1]};
    assign div_trial = div_shift - {1'b0, need};

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_valid) state_next = ST_CHECK;
            ST_CHECK: state_next = out_of_limits ? ST_DONE : ST_STEP;
            ST_STEP: begin
                if ((is_rise || is_fall) && fire && mode_reg) begin
                    state_next = ST_ABS;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_ABS:   state_next = ST_DIV;
            ST_DIV:   if (cnt_reg == DIV_LAST) state_next = ST_FIX;
            ST_FIX:   state_next = ST_DONE;
            ST_DONE:  if (load_out) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // handshake outputs and strobes
    always_comb begin
        s_ready    = (state_reg == ST_IDLE);
        take_in    = s_ready && s_valid;
        // Load the result once the output register is empty or being drained.
        load_out   = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);
        m_valid    = m_valid_reg;
        m_held_out = m_held_reg;
        m_rejected = m_rej_reg;
    end

    // datapath
    always_comb begin
        smp_next     = smp_reg;
        rej_next     = rej_reg;
        held_next    = held_reg;
        rise_next    = rise_reg;
        fall_next    = fall_reg;
        sum_next     = sum_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        neg_next     = neg_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_held_next  = m_held_reg;
        m_rej_next   = m_rej_reg;

        if (take_in) begin
            smp_next = s_sample;
        end

        unique case (state_reg)
            ST_CHECK: rej_next = out_of_limits;
            ST_STEP: begin
                if (is_rise || is_fall) begin
                    if (fire) begin
                        // Restart both runs; capture the sum for the divider.
                        rise_next = '0;
                        fall_next = '0;
                        sum_next  = '0;
                        quo_next  = sum_step;
                        neg_next  = sum_step[SUM_W-1];
                        if (!mode_reg) begin
                            held_next = {{(SUM_W-SW){smp_reg[SW-1]}}, smp_reg};
                        end
                    end else begin
                        rise_next = is_rise ? run_new : '0;
                        fall_next = is_rise ? '0 : run_new;
                        sum_next  = sum_step;
                    end
                end else begin
                    // Inside the band: drop both runs.
                    rise_next = '0;
                    fall_next = '0;
                    sum_next  = '0;
                end
            end
            ST_ABS: begin
                quo_next = neg_reg ? -quo_reg : quo_reg;
                rem_next = '0;
                cnt_next = '0;
            end
            ST_DIV: begin
                if (!div_trial[CW]) begin
                    rem_next = div_trial[CW-1:0];
                    quo_next = {quo_reg[SUM_W-2:0], 1'b1};
                end else begin
                    rem_next = div_shift[CW-1:0];
                    quo_next = {quo_reg[SUM_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + CNT_W'(1);
            end
            ST_FIX: held_next = neg_reg ? -quo_reg : quo_reg;
            ST_DONE: begin
                if (load_out) begin
                    m_valid_next = 1'b1;
                    m_held_next  = held_reg[SW-1:0];
                    m_rej_next   = rej_reg;
                end
            end
            default: begin
            end
        endcase
    end

    // configuration writes; indexes beyond the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_limit_reg <= MAX_RST;
            min_limit_reg <= MIN_RST;
            band_reg      <= '0;
            persist_reg   <= CW'(1);
            mode_reg      <= 1'b0;
        end else if (cfg_wen) begin
            unique case (cfg_addr)
                REG_MAX_LIMIT:     max_limit_reg <= cfg_wdata[SW-1:0];
                REG_MIN_LIMIT:     min_limit_reg <= cfg_wdata[SW-1:0];
                REG_BAND:          band_reg      <= cfg_wdata[BAND_W-1:0];
                REG_PERSIST_COUNT: persist_reg   <= cfg_wdata[CW-1:0];
                REG_AVERAGE_MODE:  mode_reg      <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // control and filter state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            held_reg    <= '0;
            rise_reg    <= '0;
            fall_reg    <= '0;
            sum_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            held_reg    <= held_next;
            rise_reg    <= rise_next;
            fall_reg    <= fall_next;
            sum_reg     <= sum_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        smp_reg    <= smp_next;
        rej_reg    <= rej_next;
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        neg_reg    <= neg_next;
        cnt_reg    <= cnt_next;
        m_held_reg <= m_held_next;
        m_rej_reg  <= m_rej_next;
    end

`ifndef NO_ASSERTIONS
    // An accepted beat blocks the input until the sequencer returns to idle.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready while an item is in work");

    // A rise run and a fall run never coexist.
    a_one_run: assert property (@(posedge aclk) disable iff (!aresetn)
        !((rise_reg != '0) && (fall_reg != '0)))
        else $error("rise and fall runs both active");

    // The partial remainder stays below the divisor throughout the division.
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (rem_reg < need))
        else $error("divider remainder out of range");

    // A result is loaded only when the output register is free or draining.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_held_out) && $stable(m_rejected))
        else $error("pending result overwritten");

    // A rejected sample leaves the held value untouched.
    a_reject_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE) && rej_reg |-> $stable(held_reg))
        else $error("held value moved on a rejected sample");
`endif

endmodule

`default_nettype wire

>>> tb/persistent_step_filter_core_tb.sv
// Testbench for persistent_step_filter_core: directed and random samples checked against a predictor.

module persistent_step_filter_core_tb
    import psf_pkg::*;
();

    localparam int SW       = 16;          // sample width
    localparam int CW       = 16;          // run counter width
    localparam int CFG_W    = (SW > BAND_W) ? SW : BAND_W;
    localparam int STALL_LIMIT = 4000;     // busy cycles without any beat before giving up
    localparam int SETTLE_CYCLES = 60;     // longer than the averaging path

    // One result beat: held value after the sample and the out-of-limits flag.
    typedef struct {
        logic [SW-1:0] held_out;
        logic          rejected;
    } filter_out_t;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    logic signed [SW-1:0] s_sample  = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    logic signed [SW-1:0] m_held_out;
    logic                 m_rejected;
    logic                 cfg_wen   = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    persistent_step_filter_core #(
        .SAMPLE_WIDTH(SW),
        .COUNT_WIDTH (CW)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_sample  (s_sample),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_held_out(m_held_out),
        .m_rejected(m_rejected),
        .cfg_wen   (cfg_wen),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the filter: registers and run state.
    // held and the sum are kept wider than the port; an average over a run
    // that outlived a lowered persistence can leave the 16-bit range, and
    // the filter keeps comparing against the full value.
    // ------------------------------------------------------------------
    logic signed [SW-1:0] lim_max;
    logic signed [SW-1:0] lim_min;
    logic [BAND_W-1:0]    dead_band;
    logic [CW-1:0]        persist;
    logic                 avg_mode;

    logic signed [32:0]   held;
    logic [CW-1:0]        rise_len;
    logic [CW-1:0]        fall_len;
    logic signed [32:0]   run_total;

    logic signed [SW-1:0] sample_q[$];        // samples waiting for the driver
    filter_out_t          filter_out_q[$];    // predicted beats, oldest first
    filter_out_t          oldest;

    int samples_queued = 0;   // every sample gives exactly one result beat
    int results_seen   = 0;
    int fail_count     = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int busy_cycles    = 0;

    function automatic void filter_reset();
        lim_max   = 16'sh7fff;
        lim_min   = 16'sh8000;
        dead_band = '0;
        persist   = 16'd1;
        avg_mode  = 1'b0;
        held      = '0;
        rise_len  = '0;
        fall_len  = '0;
        run_total = '0;
    endfunction

    // Settle a finished run: take the trigger sample or the run average,
    // then restart both runs and the sum.
    function automatic void settle_run(longint smp, longint need);
        longint total;
        total = run_total;
        if (avg_mode)
            held = total / need;      // truncates toward zero
        else
            held = smp;
        rise_len  = '0;
        fall_len  = '0;
        run_total = '0;
    endfunction

    // Advance the shadow filter by one accepted sample and return its beat.
    function automatic filter_out_t filter_step(logic signed [SW-1:0] smp);
        filter_out_t r;
        longint s, h, b, mx, mn, need;
        s    = smp;
        h    = held;
        b    = dead_band;
        mx   = lim_max;
        mn   = lim_min;
        need = (persist == 0) ? 1 : persist;   // zero persistence acts as one
        r.rejected = 1'b0;
        if (s > mx || s < mn) begin
            r.rejected = 1'b1;                 // state untouched
        end else if (s > h + b) begin
            if (fall_len != 0)
                run_total = '0;                // direction change restarts the sum
            fall_len = '0;
            if (rise_len != '1)
                rise_len = rise_len + 1'b1;
            run_total = run_total + s;
            if (rise_len >= need)
                settle_run(s, need);
        end else if (s < h - b) begin
            if (rise_len != 0)
                run_total = '0;
            rise_len = '0;
            if (fall_len != '1)
                fall_len = fall_len + 1'b1;
            run_total = run_total + s;
            if (fall_len >= need)
                settle_run(s, need);
        end else begin
            rise_len  = '0;
            fall_len  = '0;
            run_total = '0;
        end
        r.held_out = held[SW-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Driver: predict each accepted beat, then offer the next sample or
    // idle. Valid only drops once the current beat has gone through.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                filter_out_q.push_back(filter_step(s_sample));
            if (!s_valid || s_ready) begin
                if (sample_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_valid  <= 1'b1;
                    s_sample <= sample_q.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: stall at random, compare every result beat with the oldest
    // prediction, field by field.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            if (m_valid && m_ready) begin
                results_seen++;
                if (filter_out_q.size() == 0) begin
                    $error("unexpected result beat: held_out %0d rejected %0b",
                           m_held_out, m_rejected);
                    fail_count++;
                end else begin
                    oldest = filter_out_q.pop_front();
                    if (m_held_out !== oldest.held_out) begin
                        $error("held_out mismatch: expected %0d, actual %0d",
                               $signed(oldest.held_out), m_held_out);
                        fail_count++;
                    end
                    if (m_rejected !== oldest.rejected) begin
                        $error("rejected mismatch: expected %0b, actual %0b",
                               oldest.rejected, m_rejected);
                        fail_count++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: count busy cycles in which no beat moves on either channel.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            results_seen >= samples_queued) begin
            busy_cycles <= 0;
        end else begin
            busy_cycles <= busy_cycles + 1;
            if (busy_cycles >= STALL_LIMIT) begin
                $display("persistent_step_filter_core_tb failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_sample(int v);
        logic [31:0] w;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        w = v;
        sample_q.push_back(w[SW-1:0]);
        samples_queued++;
    endtask

    // Hold until every queued sample has produced its beat, then let the
    // averaging path run out before anything else happens.
    task automatic wait_quiet();
        while (results_seen < samples_queued)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write one register and mirror it in the shadow copy. Call only when idle.
    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, int val);
        logic [31:0] w;
        w = val;
        @(posedge aclk);
        cfg_wen   <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= w[CFG_W-1:0];
        case (idx)
            REG_MAX_LIMIT:     lim_max   = w[SW-1:0];
            REG_MIN_LIMIT:     lim_min   = w[SW-1:0];
            REG_BAND:          dead_band = w[BAND_W-1:0];
            REG_PERSIST_COUNT: persist   = w[CW-1:0];
            REG_AVERAGE_MODE:  avg_mode  = w[0];
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(posedge aclk);
        cfg_wen <= 1'b0;
    endtask

    task automatic set_filter(int mx, int mn, int bnd, int pc, int avg);
        write_reg(REG_MAX_LIMIT, mx);
        write_reg(REG_MIN_LIMIT, mn);
        write_reg(REG_BAND, bnd);
        write_reg(REG_PERSIST_COUNT, pc);
        write_reg(REG_AVERAGE_MODE, avg);
        end_writes();
    endtask

    // Mostly runs of samples clustered around a random level, long enough to
    // fire (or one or two short of it); the rest is glitches, out-of-limit samples,
    // full-range noise and the extremes.
    task automatic queue_random_samples(int n);
        int lo, hi, need, level, len, kind;
        lo = lim_min;
        hi = lim_max;
        if (lo > hi) begin
            lo = -32768;
            hi = 32767;
        end
        need = (persist == 0) ? 1 : persist;
        if (need > 6)
            need = 6;                       // huge persistence: runs never finish
        while (n > 0) begin
            kind = $urandom_range(0, 9);
            if (kind <= 5) begin
                level = lo + int'($urandom_range(0, hi - lo));
                len   = need + int'($urandom_range(0, 1));
                if ($urandom_range(0, 3) == 0)
                    len = len - 2;
                if (len < 1)
                    len = 1;
                repeat (len) begin
                    push_sample(level + int'($urandom_range(0, 30)) - 15);
                    n--;
                end
            end else begin
                case (kind)
                    7: push_sample($urandom_range(0, 1) ? lo - 1 - int'($urandom_range(0, 20))
                                                        : hi + 1 + int'($urandom_range(0, 20)));
                    9: begin
                        case ($urandom_range(0, 5))
                            0: push_sample(-32768);
                            1: push_sample(32767);
                            2: push_sample(0);
                            3: push_sample(-1);
                            4: push_sample(lo);
                            default: push_sample(hi);
                        endcase
                    end
                    default: push_sample(int'($urandom_range(0, 65535)) - 32768);
                endcase
                n--;
            end
        end
    endtask

    task automatic random_phase(int mx, int mn, int bnd, int pc, int avg,
                                int sidle, int rstall, int n);
        wait_quiet();
        set_filter(mx, mn, bnd, pc, avg);
        send_idle_pct  = sidle;
        recv_stall_pct = rstall;
        queue_random_samples(n);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        filter_reset();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Register defaults: persistence one, no band, take the sample.
        // Hit both extremes, a repeat inside the band, and small steps.
        push_sample(32767);
        push_sample(32767);
        push_sample(-32768);
        push_sample(-32768);
        push_sample(0);
        push_sample(-1);
        wait_quiet();

        // Crossed limits: every sample must come back rejected.
        write_reg(REG_MAX_LIMIT, -10);
        write_reg(REG_MIN_LIMIT, 10);
        end_writes();
        push_sample(0);
        push_sample(-32768);
        push_sample(32767);
        wait_quiet();

        // Zero persistence behaves as one.
        set_filter(32767, -32768, 0, 0, 0);
        push_sample(500);
        push_sample(200);
        wait_quiet();

        // A rise run broken by a fall run restarts the sum; switch to
        // averaging with the fall run still open so it averages all of it.
        set_filter(32767, -32768, 50, 3, 0);
        push_sample(300);
        push_sample(310);
        push_sample(100);
        push_sample(90);
        wait_quiet();
        write_reg(REG_AVERAGE_MODE, 1);
        end_writes();
        push_sample(80);
        wait_quiet();

        // Lower persistence under an open run: it fires on the next sample
        // and divides the sum of the whole run by the new persistence.
        write_reg(REG_PERSIST_COUNT, 4);
        end_writes();
        push_sample(1000);
        push_sample(1001);
        push_sample(1003);
        wait_quiet();
        write_reg(REG_PERSIST_COUNT, 2);
        end_writes();
        push_sample(1004);
        wait_quiet();

        // Widest band: nothing escapes it. Then one past each limit and the
        // limits themselves.
        set_filter(32767, -32768, 65535, 1, 0);
        push_sample(32767);
        push_sample(-32768);
        wait_quiet();
        set_filter(100, -100, 0, 1, 0);
        push_sample(101);
        push_sample(-101);
        push_sample(100);
        push_sample(-100);

        // Random phases: limits, band, persistence, mode, sender idle %,
        // receiver stall %, sample count.
        random_phase( 32767, -32768,     0,     1, 0,  0,  0, 150);
        random_phase( 32767, -32768,    40,     3, 1, 69,  0, 150);
        random_phase( 20000, -20000,   200,     4, 1,  0, 69, 150);
        random_phase( 30000,  -1000,    10,     2, 0, 28, 28, 150);
        random_phase( 32767, -32768,     0,     0, 1,  0,  0, 100);
        random_phase(  -100, -32768,  1000,     5, 1, 69,  0, 150);
        random_phase( 32767, -32768,     0, 65535, 1,  0, 69,  50);
        random_phase(  -500,    500,     0,     2, 0, 28, 28,  50);
        random_phase( 32767, -32768,     3,     3, 1, 28, 28, 150);
        random_phase( 32767, -32768,     0,     2, 1,  0,  0, 150);

        // Drain, then give stray beats time to show up.
        wait_quiet();
        if (fail_count == 0 && filter_out_q.size() == 0) begin
            $display("persistent_step_filter_core_tb passed");
        end else begin
            if (filter_out_q.size() != 0)
                $error("%0d predicted beats never arrived", filter_out_q.size());
            $display("persistent_step_filter_core_tb failed");
        end
        $finish;
    end

endmodule
